### rtl/assert_macros.svh
// Assertion macros used by the deframer's parser module.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFD_ASSERT(label, prop, msg)
`define FFD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/ffd_pkg.sv
// Types and constants of the forwarder frame deframer.
// Depends on nothing; used by ffd_parser and the top level.
package ffd_pkg;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_TYPE = 3'd1,
    PH_CTRL = 3'd2,
    PH_NODE = 3'd3,
    PH_LEN0 = 3'd4,
    PH_LENH = 3'd5,
    PH_LENL = 3'd6,
    PH_BODY = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_NODE = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_SHORT     = 2'd0;
  localparam logic [1:0] ERR_TYPE      = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT   = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

  localparam logic       ACT_BYTE    = 1'b0;
  localparam logic [7:0] FRAME_TYPE   = 8'hFE;
  localparam logic [7:0] MIN_HEADER   = 8'd4;
  localparam logic [7:0] HEADER_FIXED = 8'd3;
  localparam logic [7:0] LEN_ESCAPE   = 8'd1;
  localparam logic [15:0] LEN_LONG_MIN = 16'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  error_code;
    logic        is_broadcast;
    logic [15:0] msg_bytes;
  } out_item_t;

endpackage

### rtl/ffd_parser.sv
// Frame parser: phase machine and counters, with the result of each request.
// Depends on ffd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ffd_pkg::in_item_t item,
  output logic              res_valid,
  output ffd_pkg::out_item_t res
);

  ffd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  node_left_r, node_left_nxt;
  logic [7:0]  len_high_r, len_high_nxt;
  logic [15:0] msg_len_r, msg_len_nxt;
  logic [15:0] msg_cnt_r, msg_cnt_nxt;
  logic        bcast_r, bcast_nxt;

  logic        is_byte;
  logic [7:0]  b;
  logic [15:0] len_long;
  logic [15:0] cnt_inc;
  logic        restart;

  assign is_byte  = (item.action == ffd_pkg::ACT_BYTE);
  assign b        = item.rx_byte;
  assign len_long = {len_high_r, b};
  assign cnt_inc  = msg_cnt_r + 16'd1;
  assign restart  = accept && (phase_nxt == ffd_pkg::PH_HDR);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (!is_byte) begin
        phase_nxt = ffd_pkg::PH_HDR;
      end else begin
        case (phase_r)
          ffd_pkg::PH_HDR: begin
            phase_nxt = (b < ffd_pkg::MIN_HEADER) ? ffd_pkg::PH_HDR : ffd_pkg::PH_TYPE;
          end
          ffd_pkg::PH_TYPE: begin
            phase_nxt = (b == ffd_pkg::FRAME_TYPE) ? ffd_pkg::PH_CTRL : ffd_pkg::PH_HDR;
          end
          ffd_pkg::PH_CTRL: phase_nxt = ffd_pkg::PH_NODE;
          ffd_pkg::PH_NODE: begin
            phase_nxt = (node_left_r == 8'd1) ? ffd_pkg::PH_LEN0 : ffd_pkg::PH_NODE;
          end
          ffd_pkg::PH_LEN0: begin
            if (b == 8'd0) begin
              phase_nxt = ffd_pkg::PH_HDR;
            end else if (b == ffd_pkg::LEN_ESCAPE) begin
              phase_nxt = ffd_pkg::PH_LENH;
            end else begin
              phase_nxt = ffd_pkg::PH_BODY;
            end
          end
          ffd_pkg::PH_LENH: phase_nxt = ffd_pkg::PH_LENL;
          ffd_pkg::PH_LENL: begin
            phase_nxt = (len_long <= ffd_pkg::LEN_LONG_MIN) ? ffd_pkg::PH_HDR
                                                            : ffd_pkg::PH_BODY;
          end
          ffd_pkg::PH_BODY: begin
            phase_nxt = (cnt_inc >= msg_len_r) ? ffd_pkg::PH_HDR : ffd_pkg::PH_BODY;
          end
          default: phase_nxt = ffd_pkg::PH_HDR;
        endcase
      end
    end
  end

  always_comb begin
    node_left_nxt = node_left_r;
    len_high_nxt  = len_high_r;
    msg_len_nxt   = msg_len_r;
    msg_cnt_nxt   = msg_cnt_r;
    bcast_nxt     = bcast_r;
    if (restart) begin
      node_left_nxt = '0;
      len_high_nxt  = '0;
      msg_len_nxt   = '0;
      msg_cnt_nxt   = '0;
      bcast_nxt     = 1'b0;
    end else if (accept && is_byte) begin
      case (phase_r)
        ffd_pkg::PH_HDR:  node_left_nxt = b - ffd_pkg::HEADER_FIXED;
        ffd_pkg::PH_CTRL: bcast_nxt = b[0];
        ffd_pkg::PH_NODE: node_left_nxt = node_left_r - 8'd1;
        ffd_pkg::PH_LEN0: begin
          msg_cnt_nxt = 16'd1;
          msg_len_nxt = {8'd0, b};
        end
        ffd_pkg::PH_LENH: begin
          len_high_nxt = b;
          msg_cnt_nxt  = 16'd2;
        end
        ffd_pkg::PH_LENL: begin
          msg_len_nxt = len_long;
          msg_cnt_nxt = 16'd3;
        end
        ffd_pkg::PH_BODY: msg_cnt_nxt = cnt_inc;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = ffd_pkg::KIND_MSG;
    res.out_byte     = b;
    res.last         = 1'b0;
    res.error_code   = ffd_pkg::ERR_SHORT;
    res.is_broadcast = bcast_r;
    res.msg_bytes    = '0;
    if (!is_byte) begin
      res_valid      = (phase_r != ffd_pkg::PH_HDR);
      res.kind       = ffd_pkg::KIND_ERR;
      res.error_code = ffd_pkg::ERR_TIMEOUT;
    end else begin
      case (phase_r)
        ffd_pkg::PH_HDR: begin
          res_valid      = (b < ffd_pkg::MIN_HEADER);
          res.kind       = ffd_pkg::KIND_ERR;
          res.error_code = ffd_pkg::ERR_SHORT;
        end
        ffd_pkg::PH_TYPE: begin
          res_valid      = (b != ffd_pkg::FRAME_TYPE);
          res.kind       = ffd_pkg::KIND_ERR;
          res.error_code = ffd_pkg::ERR_TYPE;
        end
        ffd_pkg::PH_CTRL: res_valid = 1'b0;
        ffd_pkg::PH_NODE: begin
          res_valid = 1'b1;
          res.kind  = ffd_pkg::KIND_NODE;
        end
        ffd_pkg::PH_LEN0: begin
          res_valid = 1'b1;
          if (b == 8'd0) begin
            res.kind       = ffd_pkg::KIND_ERR;
            res.error_code = ffd_pkg::ERR_UNDERFLOW;
          end
        end
        ffd_pkg::PH_LENH: res_valid = 1'b1;
        ffd_pkg::PH_LENL: begin
          res_valid = 1'b1;
          if (len_long < ffd_pkg::LEN_LONG_MIN) begin
            res.kind       = ffd_pkg::KIND_ERR;
            res.error_code = ffd_pkg::ERR_UNDERFLOW;
          end else if (len_long == ffd_pkg::LEN_LONG_MIN) begin
            res.last      = 1'b1;
            res.msg_bytes = ffd_pkg::LEN_LONG_MIN;
          end
        end
        ffd_pkg::PH_BODY: begin
          res_valid = 1'b1;
          if (cnt_inc >= msg_len_r) begin
            res.last      = 1'b1;
            res.msg_bytes = cnt_inc;
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
    if (res.kind == ffd_pkg::KIND_ERR) begin
      res.out_byte     = '0;
      res.is_broadcast = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ffd_pkg::PH_HDR;
      node_left_r <= '0;
      len_high_r  <= '0;
      msg_len_r   <= '0;
      msg_cnt_r   <= '0;
      bcast_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      node_left_r <= node_left_nxt;
      len_high_r  <= len_high_nxt;
      msg_len_r   <= msg_len_nxt;
      msg_cnt_r   <= msg_cnt_nxt;
      bcast_r     <= bcast_nxt;
    end
  end

  `FFD_ASSERT_NEXT(a_timeout_restarts, accept && !is_byte, phase_r == ffd_pkg::PH_HDR && msg_cnt_r == 16'd0, "timeout did not restart the frame")
  `FFD_ASSERT_NEXT(a_last_restarts, accept && res_valid && res.last, phase_r == ffd_pkg::PH_HDR && bcast_r == 1'b0, "final message byte did not restart the frame")
  `FFD_ASSERT(a_node_count_live, phase_r != ffd_pkg::PH_NODE || node_left_r != 8'd0, "node-id phase entered with no bytes left")
  `FFD_ASSERT(a_idle_clean, phase_r != ffd_pkg::PH_HDR || (msg_len_r == 16'd0 && bcast_r == 1'b0), "idle phase holds stale frame state")

endmodule

### rtl/forwarder_frame_deframer_unit.sv
// Each byte is parsed in a single pass of the phase logic; its result is registered.
// Throughput: one request per cycle while in_stall is low.
// A held result stalls the input only while the output side itself is stalled.
// Reset: synchronous, active low; the parser returns to awaiting a header length byte
// and the output register is emptied.
// Top level of the deframer; depends on ffd_pkg and ffd_parser.
module forwarder_frame_deframer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ffd_pkg::out_item_t out_data
);

  logic               accept;
  logic               res_valid;
  ffd_pkg::out_item_t res;
  logic               out_valid_r, out_valid_nxt;
  ffd_pkg::out_item_t out_data_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  ffd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for forwarder_frame_deframer_unit: directed frames, some with hand-written
// expected results, then random well-formed and broken frames and noise, checked against a behavioural deframer.
// Depends on ffd_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;

  localparam logic ACT_TIMEOUT = 1'b1;
  localparam int   RUN_REQUESTS = 625;
  localparam int   CYCLE_LIMIT = 400000;

  typedef struct {
    ffd_pkg::in_item_t  req;
    bit                 typed;
    bit                 typed_has;
    ffd_pkg::out_item_t typed_res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ffd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ffd_pkg::out_item_t out_data;

  ffd_pkg::phase_t parse_phase;
  logic [7:0]      nodes_left;
  logic [7:0]      len_hi;
  logic [15:0]     msg_len;
  logic [15:0]     msg_cnt;
  logic            bcast_flag;

  ffd_pkg::out_item_t results_due[$];
  stim_row_t          directed_rows[$];
  ffd_pkg::in_item_t  frame_q[$];
  int                 requests_taken = 0;
  int                 fails = 0;
  int                 burst_left = 0;

  forwarder_frame_deframer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic ffd_pkg::out_item_t framing_fault(input logic [1:0] code);
    ffd_pkg::out_item_t res;
    res = '0;
    res.kind = ffd_pkg::KIND_ERR;
    res.error_code = code;
    return res;
  endfunction

  function automatic void clear_parser();
    parse_phase = ffd_pkg::PH_HDR;
    nodes_left = '0;
    len_hi = '0;
    msg_len = '0;
    msg_cnt = '0;
    bcast_flag = 1'b0;
  endfunction

  function automatic bit deframe_request(input ffd_pkg::in_item_t req,
                                         output ffd_pkg::out_item_t res);
    logic [7:0]  b;
    logic [1:0]  fault;
    bit          abort;
    bit          done;
    bit          emit;
    b = req.rx_byte;
    res = '0;
    abort = 1'b0;
    done = 1'b0;
    emit = 1'b0;
    fault = ffd_pkg::ERR_SHORT;
    if (req.action != ffd_pkg::ACT_BYTE) begin
      if (parse_phase == ffd_pkg::PH_HDR) return 1'b0;
      res = framing_fault(ffd_pkg::ERR_TIMEOUT);
      clear_parser();
      return 1'b1;
    end
    case (parse_phase)
      ffd_pkg::PH_HDR: begin
        if (b < ffd_pkg::MIN_HEADER) begin
          abort = 1'b1;
          fault = ffd_pkg::ERR_SHORT;
        end else begin
          nodes_left = b - ffd_pkg::HEADER_FIXED;
          parse_phase = ffd_pkg::PH_TYPE;
        end
      end
      ffd_pkg::PH_TYPE: begin
        if (b != ffd_pkg::FRAME_TYPE) begin
          abort = 1'b1;
          fault = ffd_pkg::ERR_TYPE;
        end else begin
          parse_phase = ffd_pkg::PH_CTRL;
        end
      end
      ffd_pkg::PH_CTRL: begin
        bcast_flag = b[0];
        parse_phase = ffd_pkg::PH_NODE;
      end
      ffd_pkg::PH_NODE: begin
        emit = 1'b1;
        res.kind = ffd_pkg::KIND_NODE;
        nodes_left = nodes_left - 8'd1;
        if (nodes_left == 8'd0) parse_phase = ffd_pkg::PH_LEN0;
      end
      ffd_pkg::PH_LEN0: begin
        if (b == 8'd0) begin
          abort = 1'b1;
          fault = ffd_pkg::ERR_UNDERFLOW;
        end else begin
          emit = 1'b1;
          res.kind = ffd_pkg::KIND_MSG;
          msg_cnt = 16'd1;
          if (b == ffd_pkg::LEN_ESCAPE) begin
            parse_phase = ffd_pkg::PH_LENH;
          end else begin
            msg_len = {8'd0, b};
            parse_phase = ffd_pkg::PH_BODY;
          end
        end
      end
      ffd_pkg::PH_LENH: begin
        emit = 1'b1;
        res.kind = ffd_pkg::KIND_MSG;
        len_hi = b;
        msg_cnt = 16'd2;
        parse_phase = ffd_pkg::PH_LENL;
      end
      ffd_pkg::PH_LENL: begin
        msg_len = {len_hi, b};
        if (msg_len < ffd_pkg::LEN_LONG_MIN) begin
          abort = 1'b1;
          fault = ffd_pkg::ERR_UNDERFLOW;
        end else begin
          emit = 1'b1;
          res.kind = ffd_pkg::KIND_MSG;
          msg_cnt = 16'd3;
          if (msg_len == ffd_pkg::LEN_LONG_MIN) done = 1'b1;
          else parse_phase = ffd_pkg::PH_BODY;
        end
      end
      default: begin
        emit = 1'b1;
        res.kind = ffd_pkg::KIND_MSG;
        msg_cnt = msg_cnt + 16'd1;
        if (msg_cnt >= msg_len) done = 1'b1;
      end
    endcase
    if (abort) begin
      res = framing_fault(fault);
      clear_parser();
      return 1'b1;
    end
    if (emit) begin
      res.out_byte = b;
      res.is_broadcast = bcast_flag;
      if (done) begin
        res.last = 1'b1;
        res.msg_bytes = msg_cnt;
        clear_parser();
      end
    end
    return emit;
  endfunction

  task automatic add_row(input logic act, input logic [7:0] b, input bit typed = 1'b0,
                         input bit has = 1'b0, input ffd_pkg::out_item_t res = '0);
    stim_row_t row;
    row.req.action = act;
    row.req.rx_byte = b;
    row.typed = typed;
    row.typed_has = has;
    row.typed_res = res;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_request(input ffd_pkg::in_item_t req, input bit typed,
                              input bit typed_has, input ffd_pkg::out_item_t typed_res);
    int                 gap;
    bit                 ignored;
    bit                 has;
    ffd_pkg::out_item_t res;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    ignored = (req.action != ffd_pkg::ACT_BYTE) && (parse_phase == ffd_pkg::PH_HDR);
    has = deframe_request(req, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) results_due.insert(results_due.size(), res);
    if (!ignored) requests_taken++;
  endtask

  task automatic queue_frame(input bit corrupt);
    int                nodes;
    int                mlen;
    int                len_idx;
    int                pos;
    int                pick;
    bit                esc;
    ffd_pkg::in_item_t item;
    frame_q.delete();
    item.action = ffd_pkg::ACT_BYTE;
    nodes = ($urandom_range(0, 99) < 3) ? $urandom_range(1, 252) : $urandom_range(1, 4);
    esc = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (esc) mlen = (pick < 5) ? $urandom_range(256, 400) : $urandom_range(3, 12);
    else mlen = (pick < 5) ? $urandom_range(200, 255) : $urandom_range(2, 12);
    item.rx_byte = 8'(nodes + 3);
    frame_q.insert(frame_q.size(), item);
    item.rx_byte = ffd_pkg::FRAME_TYPE;
    frame_q.insert(frame_q.size(), item);
    item.rx_byte = 8'($urandom);
    frame_q.insert(frame_q.size(), item);
    repeat (nodes) begin
      item.rx_byte = 8'($urandom);
      frame_q.insert(frame_q.size(), item);
    end
    len_idx = frame_q.size();
    if (esc) begin
      item.rx_byte = ffd_pkg::LEN_ESCAPE;
      frame_q.insert(frame_q.size(), item);
      item.rx_byte = 8'(mlen >> 8);
      frame_q.insert(frame_q.size(), item);
      item.rx_byte = 8'(mlen);
      frame_q.insert(frame_q.size(), item);
      repeat (mlen - 3) begin
        item.rx_byte = 8'($urandom);
        frame_q.insert(frame_q.size(), item);
      end
    end else begin
      item.rx_byte = 8'(mlen);
      frame_q.insert(frame_q.size(), item);
      repeat (mlen - 1) begin
        item.rx_byte = 8'($urandom);
        frame_q.insert(frame_q.size(), item);
      end
    end
    if (corrupt) begin
      case ($urandom_range(0, 4))
        0: begin
          pos = $urandom_range(1, frame_q.size() - 1);
          frame_q[pos].action = ACT_TIMEOUT;
        end
        1: frame_q[1].rx_byte = ffd_pkg::FRAME_TYPE ^ 8'($urandom_range(1, 255));
        2: frame_q[0].rx_byte = 8'($urandom_range(0, 3));
        3: frame_q[len_idx].rx_byte = 8'd0;
        default: begin
          if (esc) begin
            frame_q[len_idx + 1].rx_byte = 8'd0;
            frame_q[len_idx + 2].rx_byte = 8'($urandom_range(0, 2));
          end else begin
            frame_q[len_idx].rx_byte = 8'd0;
          end
        end
      endcase
      item.action = ACT_TIMEOUT;
      item.rx_byte = 8'($urandom);
      frame_q.insert(frame_q.size(), item);
    end
  endtask

  task automatic queue_noise();
    ffd_pkg::in_item_t item;
    frame_q.delete();
    repeat ($urandom_range(1, 6)) begin
      item.action = 1'($urandom_range(0, 1));
      item.rx_byte = 8'($urandom);
      frame_q.insert(frame_q.size(), item);
    end
    item.action = ACT_TIMEOUT;
    item.rx_byte = 8'($urandom);
    frame_q.insert(frame_q.size(), item);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ffd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d byte 0x%0h", out_data.kind, out_data.out_byte);
        fails++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("out_byte", want.out_byte, out_data.out_byte);
        check_field("last", want.last, out_data.last);
        check_field("error_code", want.error_code, out_data.error_code);
        check_field("is_broadcast", want.is_broadcast, out_data.is_broadcast);
        check_field("msg_bytes", want.msg_bytes, out_data.msg_bytes);
      end
    end
  end

  // The receiver switches among random stall habits and, once, holds
  // off for a long stretch so that the block backs up into its input.
  initial begin : receiver
    int          mode;
    int          mode_left;
    int unsigned tick;
    bit          held;
    mode = 0;
    mode_left = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (!held && requests_taken >= 150) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= tick[2];
      endcase
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[forwarder_frame_deframer_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    clear_parser();

    add_row(ACT_TIMEOUT, 8'h00, 1'b1, 1'b0);
    add_row(ffd_pkg::ACT_BYTE, 8'd3, 1'b1, 1'b1, framing_fault(ffd_pkg::ERR_SHORT));
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::MIN_HEADER);
    add_row(ffd_pkg::ACT_BYTE, 8'hFF, 1'b1, 1'b1, framing_fault(ffd_pkg::ERR_TYPE));
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::MIN_HEADER);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::FRAME_TYPE);
    add_row(ffd_pkg::ACT_BYTE, 8'hFF);
    add_row(ffd_pkg::ACT_BYTE, 8'hAB);
    add_row(ffd_pkg::ACT_BYTE, 8'h00, 1'b1, 1'b1, framing_fault(ffd_pkg::ERR_UNDERFLOW));
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::MIN_HEADER);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::FRAME_TYPE);
    add_row(ffd_pkg::ACT_BYTE, 8'h01);
    add_row(ffd_pkg::ACT_BYTE, 8'hFF);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::LEN_ESCAPE);
    add_row(ffd_pkg::ACT_BYTE, 8'h00);
    add_row(ffd_pkg::ACT_BYTE, 8'h03);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::MIN_HEADER);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::FRAME_TYPE);
    add_row(ffd_pkg::ACT_BYTE, 8'h00);
    add_row(ffd_pkg::ACT_BYTE, 8'h11);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::LEN_ESCAPE);
    add_row(ffd_pkg::ACT_BYTE, 8'h00);
    add_row(ffd_pkg::ACT_BYTE, 8'h02, 1'b1, 1'b1, framing_fault(ffd_pkg::ERR_UNDERFLOW));
    add_row(ffd_pkg::ACT_BYTE, 8'hFF);
    add_row(ffd_pkg::ACT_BYTE, ffd_pkg::FRAME_TYPE);
    add_row(ACT_TIMEOUT, 8'hFF, 1'b1, 1'b1, framing_fault(ffd_pkg::ERR_TIMEOUT));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_has,
                   directed_rows[i].typed_res);

    while (requests_taken < RUN_REQUESTS) begin
      if (!paused && requests_taken >= 350) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 19) == 0) queue_noise();
      else queue_frame($urandom_range(0, 19) < 4);
      foreach (frame_q[i]) send_request(frame_q[i], 1'b0, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("[forwarder_frame_deframer_unit] OK");
    end else begin
      $display("[forwarder_frame_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
